>>> rtl/phr_pkg.sv
// point history ring package: sizes, action codes and the control bundle
// shared by the controller, the point memory and the top level
// depends on nothing
package phr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int SLOT_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int AGE_W      = 8;
	localparam int COORD_W    = 16;
	localparam int POINT_W    = 2 * COORD_W;

	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_POINTS);

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SLOT_W-1:0] raddr;
		logic              ok;
		logic              rd_sel;
		logic [CNT_W-1:0]  count;
	} phr_op_t;

endpackage

>>> rtl/phr_ifs.sv
// point history ring channels: input item, result item, capacity write
// each with valid/ready and its payload
// depends on phr_pkg
interface phr_in_if;
	import phr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [AGE_W-1:0]          age_index;
	modport source (output valid, action, point_x, point_y, age_index, input ready);
	modport sink (input valid, action, point_x, point_y, age_index, output ready);
endinterface

interface phr_out_if;
	import phr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic signed [COORD_W-1:0] read_x;
	logic signed [COORD_W-1:0] read_y;
	logic [CNT_W-1:0]          stored_count;
	modport source (output valid, ok, read_x, read_y, stored_count, input ready);
	modport sink (input valid, ok, read_x, read_y, stored_count, output ready);
endinterface

interface phr_cfg_if;
	import phr_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] ring_capacity;
	modport source (output valid, ring_capacity, input ready);
	modport sink (input valid, ring_capacity, output ready);
endinterface

>>> rtl/phr_ctrl.sv
// point history ring controller: capacity, head slot and point count,
// memory addresses and result flags for each accepted beat
// depends on phr_pkg
module phr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [phr_pkg::CNT_W-1:0]    cfg_data,
	input  logic                         accept,
	input  logic [1:0]                   action,
	input  logic [phr_pkg::AGE_W-1:0]    age_index,
	output phr_pkg::phr_op_t             op
);
	import phr_pkg::*;

	logic [CNT_W-1:0]  cap_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] head_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic [AGE_W:0]    pos_sum;
	logic [AGE_W:0]    pos;
	logic              cap_nz;

	assign cap_nz  = (cap_q != '0);
	assign pos_sum = {{(AGE_W + 1 - SLOT_W){1'b0}}, head_q} + {1'b0, age_index};
	assign pos     = (pos_sum >= {{(AGE_W + 1 - CNT_W){1'b0}}, cap_q})
		? pos_sum - {{(AGE_W + 1 - CNT_W){1'b0}}, cap_q} : pos_sum;

	always_comb begin
		head_nxt  = head_q;
		count_nxt = count_q;
		op        = '0;
		op.raddr  = pos[SLOT_W-1:0];
		case (action)
			ACT_PUSH: begin
				if (cap_nz) begin
					if (head_q == '0 || {1'b0, head_q} >= cap_q)
						head_nxt = SLOT_W'(cap_q - 1'b1);
					else
						head_nxt = head_q - 1'b1;
					if (count_q < cap_q)
						count_nxt = count_q + 1'b1;
					op.we = 1'b1;
					op.ok = 1'b1;
				end
			end
			ACT_READ: begin
				if (cap_nz && age_index < {{(AGE_W - CNT_W){1'b0}}, count_q}
					&& pos < (AGE_W + 1)'(MAX_POINTS)) begin
					op.ok     = 1'b1;
					op.rd_sel = 1'b1;
				end
			end
			ACT_CLEAR: begin
				head_nxt  = '0;
				count_nxt = '0;
			end
			default: ;
		endcase
		op.waddr = head_nxt;
		op.count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_MAX;
			head_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q) else $error("point count above capacity");
	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		head_q == '0 || {1'b0, head_q} < cap_q) else $error("head slot outside ring");
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> head_q == '0 && count_q == '0) else $error("capacity write did not clear");

endmodule

>>> rtl/phr_mem.sv
// point history ring storage: one write port, one read port with
// registered read data, x in the upper half and y in the lower half
// depends on phr_pkg
module phr_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [phr_pkg::SLOT_W-1:0]    waddr,
	input  logic [phr_pkg::POINT_W-1:0]   wdata,
	input  logic                          re,
	input  logic [phr_pkg::SLOT_W-1:0]    raddr,
	output logic [phr_pkg::POINT_W-1:0]   rdata_s1
);
	import phr_pkg::*;

	logic [POINT_W-1:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_s1 <= mem[raddr];
	end

endmodule

>>> rtl/point_history_ring.sv
// point history ring top level: controller, point memory, result stage
// and output register
// depends on phr_pkg, phr_ifs, phr_ctrl, phr_mem
//
// usage
//   point:  input beats (action, point_x, point_y, age_index); push, read by age,
//           clear; one result beat per input beat, in order
//   result: ok, read_x, read_y, stored_count
//   cfg:    ring_capacity writes, always ready; values above 64 saturate,
//           a write empties the ring; write only while no beat is in flight
// latency: result.valid rises one cycle after the edge that takes the input beat
//   (memory read register at that edge, then output register)
// throughput: one beat per cycle, set by the single memory port pair
//   (one write and one read each cycle)
// reset: capacity 64, ring empty, no result pending; stored points are
//   not cleared and only slots pushed since the last clear are readable
// stall: while result.ready is low the output register holds; one more beat
//   is taken into the read stage, then point.ready drops until it moves on
module point_history_ring (
	input  logic    clk,
	input  logic    arst_n,
	phr_in_if.sink  point,
	phr_out_if.source result,
	phr_cfg_if.sink cfg
);
	import phr_pkg::*;

	phr_op_t            op;
	logic               accept;
	logic               s1_move;
	logic               valid_s1;
	logic               ok_s1;
	logic               sel_s1;
	logic [CNT_W-1:0]   count_s1;
	logic [POINT_W-1:0] rd_s1;
	logic               out_valid_q;
	logic               ok_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [CNT_W-1:0]   count_q;

	assign cfg.ready   = 1'b1;
	assign s1_move     = valid_s1 && (!out_valid_q || result.ready);
	assign point.ready = !valid_s1 || s1_move;
	assign accept      = point.valid && point.ready;

	phr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.ring_capacity),
		.accept    (accept),
		.action    (point.action),
		.age_index (point.age_index),
		.op        (op)
	);

	phr_mem u_mem (
		.clk      (clk),
		.we       (accept && op.we),
		.waddr    (op.waddr),
		.wdata    ({point.point_x, point.point_y}),
		.re       (accept),
		.raddr    (op.raddr),
		.rdata_s1 (rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1    <= op.ok;
			sel_s1   <= op.rd_sel;
			count_s1 <= op.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ok_q    <= ok_s1;
			x_q     <= sel_s1 ? rd_s1[POINT_W-1:COORD_W] : '0;
			y_q     <= sel_s1 ? rd_s1[COORD_W-1:0] : '0;
			count_q <= count_s1;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.ok           = ok_q;
	assign result.read_x       = x_q;
	assign result.read_y       = y_q;
	assign result.stored_count = count_q;

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(count_s1) && $stable(rd_s1))
		else $error("read stage lost its beat");
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |-> !point.ready)
		else $error("beat taken over a blocked read stage");
	a_sel_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sel_s1 |-> ok_s1)
		else $error("read data selected without a hit");

endmodule

>>> verif/tb_point_history_ring.sv
// testbench for point_history_ring: random and directed push, read, clear and spare beats
// checked against a mirror of the ring kept in a small scoreboard class
// depends on phr_pkg, phr_ifs and point_history_ring from rtl
module tb_point_history_ring;
	import phr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int         NUM_PHASES = 13;
	localparam int         PHASE_BEATS = 140;

	typedef struct {
		logic                      ok;
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic [CNT_W-1:0]          cnt;
	} answer_t;

	class ring_mirror;
		logic signed [COORD_W-1:0] slot_x [MAX_POINTS];
		logic signed [COORD_W-1:0] slot_y [MAX_POINTS];
		logic [SLOT_W-1:0]         head;
		logic [CNT_W-1:0]          count;
		logic [CNT_W-1:0]          capacity;
		answer_t                   pending_answers [$];
		int errors, beats, pushes, reads, hits, clears, cap_writes;

		function new();
			foreach (slot_x[i]) begin
				slot_x[i] = '0;
				slot_y[i] = '0;
			end
			head = '0;
			count = '0;
			capacity = CAP_MAX;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] value);
			capacity = (value > CAP_MAX) ? CAP_MAX : value;
			head = '0;
			count = '0;
			cap_writes++;
		endfunction

		function void take_beat(logic [1:0] act, logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y, logic [AGE_W-1:0] age);
			answer_t     a;
			int unsigned pos;
			a.ok = 1'b0;
			a.rx = '0;
			a.ry = '0;
			beats++;
			case (act)
				ACT_PUSH: begin
					pushes++;
					if (capacity != 0) begin
						if (head == 0 || head >= capacity)
							head = SLOT_W'(capacity - 1);
						else
							head = head - 1'b1;
						slot_x[head] = x;
						slot_y[head] = y;
						if (count < capacity)
							count = count + 1'b1;
						a.ok = 1'b1;
					end
				end
				ACT_READ: begin
					reads++;
					if (capacity != 0 && age < count) begin
						pos = head + age;
						if (pos >= capacity)
							pos = pos - capacity;
						a.ok = 1'b1;
						a.rx = slot_x[pos];
						a.ry = slot_y[pos];
						hits++;
					end
				end
				ACT_CLEAR: begin
					clears++;
					head = '0;
					count = '0;
				end
				default: ;
			endcase
			a.cnt = count;
			pending_answers.push_back(a);
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		task check_beat(logic ok, logic signed [COORD_W-1:0] rx,
				logic signed [COORD_W-1:0] ry, logic [CNT_W-1:0] cnt);
			answer_t want;
			if (pending_answers.size() == 0) begin
				report("result beat with no pending answer");
				return;
			end
			want = pending_answers.pop_front();
			if (ok !== want.ok)
				report($sformatf("ok got %0b want %0b", ok, want.ok));
			if (rx !== want.rx)
				report($sformatf("read_x got %0d want %0d", rx, want.rx));
			if (ry !== want.ry)
				report($sformatf("read_y got %0d want %0d", ry, want.ry));
			if (cnt !== want.cnt)
				report($sformatf("stored_count got %0d want %0d", cnt, want.cnt));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm_tx;
	bit   calm_rx;
	ring_mirror board;

	int phase_cap [NUM_PHASES] = '{127, 0, 1, 2, 3, 64, 5, 100, 7, 63, 1, 4, 64};
	int phase_push [NUM_PHASES] = '{70, 40, 45, 45, 45, 60, 45, 55, 45, 65, 45, 45, 45};
	int phase_clear [NUM_PHASES] = '{1, 5, 5, 5, 4, 2, 4, 1, 4, 1, 3, 5, 6};

	phr_in_if  point_bus ();
	phr_out_if result_bus ();
	phr_cfg_if cfg_bus ();

	point_history_ring uut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 11))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return -16'sd1;
			3: return 16'sd0;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_beat(logic [1:0] act, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic [AGE_W-1:0] age);
		int gap;
		point_bus.valid <= 1'b1;
		point_bus.action <= act;
		point_bus.point_x <= x;
		point_bus.point_y <= y;
		point_bus.age_index <= age;
		do @(posedge clk); while (!point_bus.ready);
		board.take_beat(act, x, y, age);
		gap = calm_tx ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 39) == 0)
			calm_tx = !calm_tx;
		if (gap > 0) begin
			point_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		point_bus.valid <= 1'b0;
		while (board.pending_answers.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] value);
		wait_idle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.ring_capacity <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		board.set_capacity(value);
	endtask

	task automatic random_phase(int n, int push_w, int clear_w);
		logic [1:0]       act;
		logic [AGE_W-1:0] age;
		int               r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_w)
				act = ACT_PUSH;
			else if (r < push_w + clear_w)
				act = ACT_CLEAR;
			else if (r < push_w + clear_w + 3)
				act = ACT_SPARE;
			else
				act = ACT_READ;
			if ($urandom_range(0, 4) == 0)
				age = AGE_W'($urandom_range(0, 255));
			else
				age = AGE_W'($urandom_range(0, board.count + 1));
			send_beat(act, pick_coord(), pick_coord(), age);
		end
	endtask

	initial begin
		int hold;
		hold = 0;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				board.check_beat(result_bus.ok, result_bus.read_x, result_bus.read_y,
					result_bus.stored_count);
				hold = calm_rx ? 0 : $urandom_range(0, 18);
				if ($urandom_range(0, 39) == 0)
					calm_rx = !calm_rx;
				result_bus.ready <= (hold == 0);
			end else if (hold > 0) begin
				hold--;
				if (hold == 0)
					result_bus.ready <= 1'b1;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		board = new();
		arst_n <= 1'b0;
		point_bus.valid <= 1'b0;
		point_bus.action <= ACT_PUSH;
		point_bus.point_x <= '0;
		point_bus.point_y <= '0;
		point_bus.age_index <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.ring_capacity <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity, extremes, overflowing ages, spare code, clear
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_PUSH, 16'sh7fff, 16'sh8000, 8'd0);
		send_beat(ACT_PUSH, 16'sh8000, 16'sh7fff, 8'd0);
		send_beat(ACT_PUSH, -16'sd1, 16'sd0, 8'd0);
		send_beat(ACT_PUSH, 16'sd0, -16'sd1, 8'd255);
		for (int a = 0; a < 4; a++)
			send_beat(ACT_READ, 16'sd0, 16'sd0, AGE_W'(a));
		send_beat(ACT_READ, -16'sd1, -16'sd1, 8'd4);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd255);
		send_beat(ACT_SPARE, -16'sd1, -16'sd1, 8'd255);
		send_beat(ACT_CLEAR, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_PUSH, 16'sh5555, 16'shaaaa, 8'd0);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd0);

		// disabled ring
		write_capacity(7'd0);
		send_beat(ACT_PUSH, 16'sd123, -16'sd456, 8'd0);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_CLEAR, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_SPARE, 16'sd0, 16'sd0, 8'd0);

		// single slot, overwrite on every push
		write_capacity(7'd1);
		send_beat(ACT_PUSH, 16'sd11, 16'sd22, 8'd0);
		send_beat(ACT_PUSH, 16'sd33, 16'sd44, 8'd0);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd0);
		send_beat(ACT_READ, 16'sd0, 16'sd0, 8'd1);

		phase_cap[10] = $urandom_range(1, 64);
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(CNT_W'(phase_cap[p]));
			random_phase(PHASE_BEATS, phase_push[p], phase_clear[p]);
		end

		wait_idle();
		$display("run covered %0d beats: %0d pushes, %0d reads (%0d found), %0d clears",
			board.beats, board.pushes, board.reads, board.hits, board.clears);
		$display("over %0d capacity writes including zero and saturating values",
			board.cap_writes);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d answers pending", board.pending_answers.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
